>>> src/assert_macros.svh
// Assertion macros shared by the RTL modules of the HSMS auto-responder.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/hfar_pkg.sv
// Shared types and constants for the HSMS frame auto-responder.
// No dependencies; used by every RTL module of the block.
package hfar_pkg;

	localparam int HEADER_BYTES = 10;
	localparam int DIGIT_BYTES  = 14;
	localparam int PKT_BYTES    = 30;
	localparam int LEN_W        = 21;

	localparam logic [LEN_W-1:0] LENGTH_CAP  = 21'h100000;
	localparam logic [31:0]      MIN_LENGTH  = 32'd10;
	localparam logic [3:0]       RESYNC_DROP = 4'd10;

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} hfar_in_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_last;
	} hfar_out_t;

	// Completed message: header bytes plus date/time as ASCII digits.
	typedef struct packed {
		logic [HEADER_BYTES-1:0][7:0] header;
		logic [DIGIT_BYTES-1:0][7:0]  digits;
	} hfar_msg_t;

	// Reply packet ready for the transmit queue.
	typedef struct packed {
		logic                      has_reply;
		logic [4:0]                len;
		logic [PKT_BYTES-1:0][7:0] bytes;
	} hfar_pkt_t;

endpackage

>>> src/hfar_deframer.sv
// Input register and HSMS deframer: length check, resync drop, header capture.
// Emits one completed message per frame end. Depends on hfar_pkg, assert_macros.svh.
`include "assert_macros.svh"

module hfar_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  hfar_pkg::hfar_in_t          in_data,
	input  logic [hfar_pkg::LEN_W-1:0]  max_len,
	output logic                        msg_valid,
	input  logic                        msg_ready,
	output hfar_pkg::hfar_msg_t         msg
);

	function automatic logic [15:0] two_digits(input logic [5:0] v);
		logic [3:0] t;
		logic [5:0] u;
		t = '0;
		for (int k = 1; k <= 6; k++) begin
			if (v >= 6'(k * 10)) t = 4'(k);
		end
		u = v - 6'(t * 10);
		return {8'h30 | {4'h0, t}, 8'h30 | {4'h0, u[3:0]}};
	endfunction

	function automatic logic [31:0] year_digits(input logic [13:0] y);
		logic [13:0] ym;
		logic [3:0]  th, hu, te;
		logic [9:0]  r1;
		logic [6:0]  r2, un;
		ym = (y >= 14'd10000) ? y - 14'd10000 : y;
		th = '0;
		for (int k = 1; k <= 9; k++) begin
			if (ym >= 14'(k * 1000)) th = 4'(k);
		end
		r1 = 10'(ym - 14'(th * 1000));
		hu = '0;
		for (int k = 1; k <= 9; k++) begin
			if (r1 >= 10'(k * 100)) hu = 4'(k);
		end
		r2 = 7'(r1 - 10'(hu * 100));
		te = '0;
		for (int k = 1; k <= 9; k++) begin
			if (r2 >= 7'(k * 10)) te = 4'(k);
		end
		un = r2 - 7'(te * 10);
		return {8'h30 | {4'h0, th}, 8'h30 | {4'h0, hu}, 8'h30 | {4'h0, te},
			8'h30 | {4'h0, un[3:0]}};
	endfunction

	logic                                  valid_s1;
	hfar_pkg::hfar_in_t                    item_s1;
	logic                                  valid_s2;
	hfar_pkg::hfar_msg_t                   msg_s2;

	logic [hfar_pkg::LEN_W-1:0]            pos_q, pos_d;
	logic [hfar_pkg::LEN_W-1:0]            len_q, len_d;
	logic [23:0]                           asm_q, asm_d;
	logic [3:0]                            resync_q, resync_d;
	logic [hfar_pkg::HEADER_BYTES-1:0][7:0] hdr_q, hdr_d;

	logic                                  done_now;
	logic                                  adv;
	logic [hfar_pkg::LEN_W-1:0]            lim;
	logic [31:0]                           new_len;
	logic [hfar_pkg::LEN_W-1:0]            hofs;
	logic [hfar_pkg::DIGIT_BYTES-1:0][7:0] digits;

	assign lim      = (max_len > hfar_pkg::LENGTH_CAP) ? hfar_pkg::LENGTH_CAP : max_len;
	assign new_len  = {asm_q, item_s1.rx_byte};
	assign hofs     = pos_q - 21'd4;
	assign done_now = (resync_q == '0) && (pos_q >= 21'd4) && (pos_q == len_q + 21'd3);
	// Only a frame end needs the message slot; every other byte moves on at once.
	assign adv      = valid_s1 && (!done_now || !valid_s2 || msg_ready);
	assign in_ready = !valid_s1 || adv;

	always_comb begin
		pos_d    = pos_q;
		len_d    = len_q;
		asm_d    = asm_q;
		resync_d = resync_q;
		hdr_d    = hdr_q;
		if (resync_q != '0) begin
			resync_d = resync_q - 4'd1;
			if (resync_q == 4'd1) pos_d = '0;
		end else if (pos_q < 21'd4) begin
			asm_d = (pos_q == '0) ? {16'h0, item_s1.rx_byte} : {asm_q[15:0], item_s1.rx_byte};
			if (pos_q == 21'd3 &&
				(new_len < hfar_pkg::MIN_LENGTH || new_len > {11'h0, lim})) begin
				resync_d = hfar_pkg::RESYNC_DROP;
				pos_d    = '0;
			end else begin
				if (pos_q == 21'd3) len_d = new_len[hfar_pkg::LEN_W-1:0];
				pos_d = pos_q + 21'd1;
			end
		end else begin
			if (hofs < 21'(hfar_pkg::HEADER_BYTES)) hdr_d[hofs[3:0]] = item_s1.rx_byte;
			pos_d = done_now ? '0 : pos_q + 21'd1;
		end
	end

	assign digits = {year_digits(item_s1.year),
		two_digits({2'b0, item_s1.month}),
		two_digits({1'b0, item_s1.day}),
		two_digits({1'b0, item_s1.hour}),
		two_digits(item_s1.minute),
		two_digits(item_s1.second)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pos_q    <= '0;
			len_q    <= '0;
			asm_q    <= '0;
			resync_q <= '0;
		end else begin
			if (in_valid && in_ready) valid_s1 <= 1'b1;
			else if (adv)             valid_s1 <= 1'b0;
			if (adv && done_now)      valid_s2 <= 1'b1;
			else if (msg_ready)       valid_s2 <= 1'b0;
			if (adv) begin
				pos_q    <= pos_d;
				len_q    <= len_d;
				asm_q    <= asm_d;
				resync_q <= resync_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_s1 <= in_data;
		if (adv) hdr_q <= hdr_d;
		// digits are packed most significant first: index 13 is the first year digit
		if (adv && done_now) begin
			msg_s2.header <= hdr_d;
			msg_s2.digits <= digits;
		end
	end

	assign msg_valid = valid_s2;
	assign msg       = msg_s2;

	`ASSERT_IMPLIES(a_resync_pos, resync_q != '0, pos_q == '0, "resync with frame in progress")
	`ASSERT_IMPLIES(a_slot_free, adv && done_now, !valid_s2 || msg_ready,
		"message slot overwritten")
	`ASSERT_IMPLIES(a_pos_bound, resync_q == '0 && pos_q >= 21'd4, pos_q <= len_q + 21'd3,
		"byte position ran past frame end")

endmodule

>>> src/hfar_reply_build.sv
// Reply composer: classifies a completed message and lays out the reply packet.
// Pure combinational logic. Depends on hfar_pkg.
module hfar_reply_build (
	input  hfar_pkg::hfar_msg_t msg,
	output hfar_pkg::hfar_pkt_t pkt
);

	localparam logic [15:0] CONTROL_SESSION = 16'hFFFF;
	localparam logic [7:0]  ST_SELECT_REQ   = 8'h01;
	localparam logic [7:0]  ST_SELECT_RSP   = 8'h02;
	localparam logic [7:0]  ST_DESELECT_REQ = 8'h03;
	localparam logic [7:0]  ST_DESELECT_RSP = 8'h04;
	localparam logic [7:0]  ST_LINKTEST_REQ = 8'h05;
	localparam logic [7:0]  ST_LINKTEST_RSP = 8'h06;

	localparam logic [14:0] KEY_S1F1  = {7'd1, 8'd1};
	localparam logic [14:0] KEY_S1F3  = {7'd1, 8'd3};
	localparam logic [14:0] KEY_S1F13 = {7'd1, 8'd13};
	localparam logic [14:0] KEY_S1F15 = {7'd1, 8'd15};
	localparam logic [14:0] KEY_S1F17 = {7'd1, 8'd17};
	localparam logic [14:0] KEY_S2F17 = {7'd2, 8'd17};
	localparam logic [14:0] KEY_S2F31 = {7'd2, 8'd31};
	localparam logic [14:0] KEY_S2F33 = {7'd2, 8'd33};
	localparam logic [14:0] KEY_S2F35 = {7'd2, 8'd35};
	localparam logic [14:0] KEY_S2F37 = {7'd2, 8'd37};

	localparam logic [7:0] BODY_S1F2 [2]   = '{8'h01, 8'h00};
	localparam logic [7:0] BODY_S1F4 [14]  = '{8'h01, 8'h02, 8'hB1, 8'h04, 8'h00, 8'h00,
		8'h00, 8'h0B, 8'hB1, 8'h04, 8'h00, 8'h00, 8'h00, 8'h0C};
	localparam logic [7:0] BODY_S1F14 [14] = '{8'h01, 8'h02, 8'h21, 8'h01, 8'h00, 8'h01,
		8'h02, 8'h41, 8'h02, 8'h31, 8'h30, 8'h41, 8'h01, 8'h30};
	localparam logic [7:0] BODY_ACK0 [3]   = '{8'h21, 8'h01, 8'h00};

	logic [7:0]  h [hfar_pkg::HEADER_BYTES];
	logic [7:0]  rh [hfar_pkg::HEADER_BYTES];
	logic [7:0]  body [16];
	logic [4:0]  blen;
	logic [7:0]  st;
	logic [7:0]  b3lo;
	logic [14:0] key;
	logic [7:0]  code;
	logic        ok;

	always_comb begin
		for (int i = 0; i < hfar_pkg::HEADER_BYTES; i++) h[i] = msg.header[i];
		rh   = h;
		body = '{default: 8'h00};
		blen = '0;
		ok   = 1'b0;
		code = '0;
		st   = 8'hFF;
		b3lo = {1'b0, h[3][6:0]};
		key  = {h[2][6:0], h[3]};

		if ({h[0], h[1]} == CONTROL_SESSION) begin
			// SType from byte 3 (low 7 bits) first, byte 5 as fallback
			if (b3lo != '0)     st = b3lo;
			else if (h[5] != '0) st = h[5];
			ok = 1'b1;
			case (st)
				ST_SELECT_REQ: begin
					if (b3lo == ST_SELECT_REQ) rh[3] = {h[3][7], 7'h00} | ST_SELECT_RSP;
					if (h[5] == ST_SELECT_REQ) rh[5] = ST_SELECT_RSP;
				end
				ST_LINKTEST_REQ: begin
					if (h[5] == ST_LINKTEST_REQ) rh[5] = ST_LINKTEST_RSP;
					else rh[3] = ST_LINKTEST_RSP;
				end
				ST_DESELECT_REQ: begin
					if (h[5] == ST_DESELECT_REQ) rh[5] = ST_DESELECT_RSP;
					else rh[3] = ST_DESELECT_RSP;
				end
				default: ok = 1'b0;
			endcase
		end else if (h[2][7]) begin
			ok = 1'b1;
			for (int i = 0; i < 3; i++) body[i] = BODY_ACK0[i];
			blen = 5'd3;
			case (key)
				KEY_S1F1: begin
					code = 8'h02;
					for (int i = 0; i < 2; i++) body[i] = BODY_S1F2[i];
					blen = 5'd2;
				end
				KEY_S1F3: begin
					code = 8'h04;
					for (int i = 0; i < 14; i++) body[i] = BODY_S1F4[i];
					blen = 5'd14;
				end
				KEY_S1F13: begin
					code = 8'h0E;
					for (int i = 0; i < 14; i++) body[i] = BODY_S1F14[i];
					blen = 5'd14;
				end
				KEY_S1F15: code = 8'h10;
				KEY_S1F17: code = 8'h12;
				KEY_S2F17: begin
					code    = 8'h12;
					body[0] = 8'h41;
					body[1] = 8'h0E;
					for (int i = 0; i < hfar_pkg::DIGIT_BYTES; i++)
						body[2 + i] = msg.digits[hfar_pkg::DIGIT_BYTES - 1 - i];
					blen = 5'd16;
				end
				KEY_S2F31: code = 8'h20;
				KEY_S2F33: code = 8'h22;
				KEY_S2F35: code = 8'h24;
				KEY_S2F37: code = 8'h26;
				default:   ok = 1'b0;
			endcase
			rh[2] = {1'b0, h[2][6:0]};
			rh[3] = code;
			rh[4] = 8'h00;
			rh[5] = 8'h00;
		end

		pkt.has_reply = ok;
		pkt.len       = 5'd14 + blen;
		pkt.bytes     = '0;
		pkt.bytes[3]  = 8'd10 + {3'b0, blen};
		for (int i = 0; i < hfar_pkg::HEADER_BYTES; i++) pkt.bytes[4 + i] = rh[i];
		for (int i = 0; i < 16; i++) pkt.bytes[14 + i] = body[i];
	end

endmodule

>>> src/hfar_tx_queue.sv
// Transmit shift register: holds one reply packet and sends it a byte per transfer.
// Depends on hfar_pkg, assert_macros.svh.
`include "assert_macros.svh"

module hfar_tx_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_valid,
	output logic                load_ready,
	input  hfar_pkg::hfar_pkt_t pkt,
	output logic                out_valid,
	input  logic                out_ready,
	output hfar_pkg::hfar_out_t out_data
);

	logic [hfar_pkg::PKT_BYTES-1:0][7:0] pkt_q;
	logic [4:0]                          cnt_q;
	logic                                xfer;
	logic                                load;

	assign out_valid        = (cnt_q != '0);
	assign xfer             = out_valid && out_ready;
	// free now, or the last byte leaves this cycle
	assign load_ready       = (cnt_q == '0) || (cnt_q == 5'd1 && out_ready);
	assign load             = load_valid && load_ready;
	assign out_data.tx_byte = pkt_q[0];
	assign out_data.tx_last = (cnt_q == 5'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= pkt.len;
		end else if (xfer) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) pkt_q <= pkt.bytes;
		else if (xfer) pkt_q <= {8'h00, pkt_q[hfar_pkg::PKT_BYTES-1:1]};
	end

	`ASSERT_ALWAYS(a_cnt_range, cnt_q <= 5'(hfar_pkg::PKT_BYTES), "byte count out of range")
	`ASSERT_NEXT(a_cnt_step, xfer && !load, cnt_q == $past(cnt_q) - 5'd1,
		"byte count did not step on transfer")
	`ASSERT_NEXT(a_load_len, load, cnt_q >= 5'd14, "loaded packet shorter than a header")

endmodule

>>> src/hsms_frame_auto_responder_top.sv
// Top level of the HSMS frame auto-responder: config register and block wiring.
// Depends on hfar_pkg, hfar_deframer, hfar_reply_build, hfar_tx_queue.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------
//  in       | in_valid / in_ready    | in_data  (hfar_in_t)
//  out      | out_valid / out_ready  | out_data (hfar_out_t)
//  cfg      | cfg_we (no wait)       | cfg_wdata (max_length, 21b)
//
// One received byte per cycle while in_ready is high; the last byte of a message
// passes the input register, message register and tx register before the first reply byte.
// A reply packet is 14 to 30 bytes, sent one per cycle while out_ready is high.
// in_ready drops only when a byte that ends a message finds the tx register and
// the message register both occupied. Reset leaves max_length at 1048576.
module hsms_frame_auto_responder_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  hfar_pkg::hfar_in_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output hfar_pkg::hfar_out_t        out_data,
	input  logic                       cfg_we,
	input  logic [hfar_pkg::LEN_W-1:0] cfg_wdata
);

	logic [hfar_pkg::LEN_W-1:0] max_len_q;
	logic                       msg_valid;
	logic                       msg_ready;
	hfar_pkg::hfar_msg_t        msg;
	hfar_pkg::hfar_pkt_t        pkt;
	logic                       load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= hfar_pkg::LENGTH_CAP;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	hfar_deframer u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.max_len   (max_len_q),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg       (msg)
	);

	hfar_reply_build u_build (
		.msg (msg),
		.pkt (pkt)
	);

	// messages with no reply are dropped without waiting on the tx side
	assign msg_ready = !pkt.has_reply || load_ready;

	hfar_tx_queue u_txq (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (msg_valid && pkt.has_reply),
		.load_ready (load_ready),
		.pkt        (pkt),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
